@@ rtl/core/button_click_autorepeat_top_defines.svh @@
// Assertion macros shared by the button click / auto repeat RTL.
`ifndef BUTTON_CLICK_AUTOREPEAT_TOP_DEFINES_SVH
`define BUTTON_CLICK_AUTOREPEAT_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/bca_pkg.sv @@
// Package: shared constants and types for the button click / auto repeat block.
`default_nettype none

package bca_pkg;

   localparam int BUTTON_COUNT = 3;
   localparam int TIME_W       = 32;
   localparam int CFG_W        = 16;

   typedef logic [TIME_W-1:0]       time_type;
   typedef logic [CFG_W-1:0]        cfg_ms_type;
   typedef logic [BUTTON_COUNT-1:0] btn_vec_type;

   typedef enum logic [1:0] {
      CSR_GUARD    = 2'd0,
      CSR_START    = 2'd1,
      CSR_INTERVAL = 2'd2,
      CSR_MASK     = 2'd3
   } csr_idx_type;

   localparam cfg_ms_type GUARD_RESET    = 16'd50;
   localparam cfg_ms_type START_RESET    = 16'd500;
   localparam cfg_ms_type INTERVAL_RESET = 16'd150;
   localparam btn_vec_type MASK_RESET    = btn_vec_type'(6);

   // Timing settings fanned out to every button unit.
   typedef struct packed {
      cfg_ms_type guard;
      cfg_ms_type start;
      cfg_ms_type interval;
   } timing_type;

endpackage

`default_nettype wire

@@ rtl/core/bca_button.sv @@
// Per-button state: level, press/repeat/event times, click and repeat decisions.
`default_nettype none
`include "button_click_autorepeat_top_defines.svh"

module bca_button
   import bca_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire time_type   now,
   input  wire logic       level,
   input  wire logic       enable,
   input  wire timing_type timing,
   output logic            click,
   output logic            repeat_hit
);

   logic     held_ff;
   time_type pressed_ff, pressed_in;
   time_type repeat_ff,  repeat_in;
   time_type event_ff,   event_in;

   logic     edge_seen;
   logic     guard_ok;
   logic     accepted;
   logic     press_nz;
   logic     start_ok;
   logic     interval_ok;
   time_type since_event;
   time_type since_press;
   time_type since_repeat;

   always_comb begin
      edge_seen    = (level != held_ff);
      since_event  = now - event_ff;
      since_press  = now - pressed_ff;
      since_repeat = now - repeat_ff;
      guard_ok     = (since_event >= time_type'(timing.guard));
      accepted     = edge_seen && guard_ok;
      click        = accepted && level;

      // On a press edge both times become now, so the elapsed times are zero.
      press_nz    = edge_seen ? (now != '0) : (pressed_ff != '0);
      start_ok    = edge_seen ? (timing.start == '0)
                              : (since_press >= time_type'(timing.start));
      interval_ok = edge_seen ? (timing.interval == '0)
                              : (since_repeat >= time_type'(timing.interval));

      repeat_hit = !click && enable && level && press_nz && start_ok && interval_ok;

      pressed_in = pressed_ff;
      repeat_in  = repeat_ff;
      event_in   = event_ff;
      if (edge_seen) begin
         pressed_in = level ? now : '0;
         repeat_in  = level ? now : '0;
      end
      if (accepted) begin
         event_in = now;
      end
      if (repeat_hit) begin
         repeat_in = now;
         event_in  = now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= 1'b0;
         pressed_ff <= '0;
         repeat_ff  <= '0;
         event_ff   <= '0;
      end else if (step) begin
         held_ff    <= level;
         pressed_ff <= pressed_in;
         repeat_ff  <= repeat_in;
         event_ff   <= event_in;
      end
   end

   `BCA_ASSERT_IMP(a_click_rpt_excl, clock, reset, step, !(click && repeat_hit), "click and repeat together")
   `BCA_ASSERT_IMP(a_click_on_press, clock, reset, step && click, !held_ff && level, "click without a press edge")
   `BCA_ASSERT_NXT(a_release_clears, clock, reset, step && !level, pressed_ff == '0 && repeat_ff == '0, "release left times set")
   `BCA_ASSERT_NXT(a_repeat_stamps, clock, reset, step && repeat_hit, repeat_ff == $past(now) && event_ff == $past(now), "repeat did not stamp times")

endmodule

`default_nettype wire

@@ rtl/core/button_click_autorepeat_top.sv @@
// Top level: press guard and auto repeat for a group of buttons.
// A transaction taken into the input register moves to the result register (rsp_valid).
// Throughput: one transaction per cycle when rsp_stall is low, set by the single
// compute stage between the two registers; rsp_stall backs up through req_stall.
// Reset (synchronous): all buttons released, all times zero, registers at defaults.
`default_nettype none

module button_click_autorepeat_top
   import bca_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire time_type     req_now_ms,
   input  wire btn_vec_type  req_pin_levels,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output btn_vec_type       rsp_click_events,
   output btn_vec_type       rsp_repeat_events,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire csr_idx_type  csr_index,
   input  wire cfg_ms_type   csr_data
);

   timing_type  timing_ff;
   btn_vec_type enable_ff;

   logic        in_vld_ff, in_vld_in;
   time_type    now_ff;
   btn_vec_type lvl_ff;

   logic        out_vld_ff, out_vld_in;
   btn_vec_type click_ff;
   btn_vec_type rpt_ff;

   logic        advance;
   logic        req_take;
   btn_vec_type click_w;
   btn_vec_type rpt_w;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.guard    <= GUARD_RESET;
         timing_ff.start    <= START_RESET;
         timing_ff.interval <= INTERVAL_RESET;
         enable_ff          <= MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GUARD:    timing_ff.guard    <= csr_data;
            CSR_START:    timing_ff.start    <= csr_data;
            CSR_INTERVAL: timing_ff.interval <= csr_data;
            CSR_MASK:     enable_ff          <= csr_data[BUTTON_COUNT-1:0];
            default:      ;
         endcase
      end
   end

   // The held transaction moves on when the result register is free or draining.
   always_comb begin
      advance    = in_vld_ff && (!out_vld_ff || !rsp_stall);
      req_stall  = in_vld_ff && !advance;
      req_take   = req_valid && !req_stall;
      in_vld_in  = req_take || (in_vld_ff && !advance);
      out_vld_in = advance || (out_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         now_ff <= req_now_ms;
         lvl_ff <= req_pin_levels;
      end
      if (advance) begin
         click_ff <= click_w;
         rpt_ff   <= rpt_w;
      end
   end

   for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
      bca_button u_button (
         .clock      (clock),
         .reset      (reset),
         .step       (advance),
         .now        (now_ff),
         .level      (lvl_ff[i]),
         .enable     (enable_ff[i]),
         .timing     (timing_ff),
         .click      (click_w[i]),
         .repeat_hit (rpt_w[i])
      );
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_click_events  = click_ff;
   assign rsp_repeat_events = rpt_ff;

endmodule

`default_nettype wire
